@@ rtl/arpc_pkg.sv @@
// Shared types, constants and codes of the ARP cache table.
package arpc_pkg;

  localparam int TableDepth = 16;
  localparam int IntfCount  = 16;

  localparam int ModeW   = 3;
  localparam int IpW     = 32;
  localparam int MacW    = 48;
  localparam int IntfW   = 4;
  localparam int StatusW = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_LOOKUP  = 3'd0,
    MODE_ADD     = 3'd1,
    MODE_ADD_UNR = 3'd2,
    MODE_RESOLVE = 3'd3,
    MODE_DELETE  = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_RESOLVED  = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_UPD_MAC,
    OP_RESOLVE,
    OP_CLEAR
  } cell_op_e;

  typedef struct packed {
    logic             valid;
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
    logic [IntfW-1:0] intf;
    logic             resolved;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e         op;
    logic             cmp_en;
    logic [IpW-1:0]   key;
    logic [MacW-1:0]  mac;
    logic [IntfW-1:0] intf;
    logic             resolved;
  } cell_cmd_t;

endpackage

@@ rtl/arpc_cell.sv @@
// One slot of the ARP cache: stores an entry, compares it and moves it along the row.
module arpc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arpc_pkg::cell_cmd_t cmd_i,
  input  arpc_pkg::entry_t   prev_i,
  input  arpc_pkg::entry_t   next_i,
  input  logic               seen_i,
  output logic               seen_o,
  output logic               first_o,
  output arpc_pkg::entry_t   entry_o
);

  logic             valid_q, valid_d;
  logic             match_q, match_d;
  arpc_pkg::entry_t data_q, data_d;

  // A match is the first one when no cell nearer the front matched.
  assign first_o = match_q & ~seen_i;
  assign seen_o  = match_q | seen_i;

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

  always_comb begin
    match_d = match_q;
    if (cmd_i.cmp_en) begin
      match_d = valid_q && (data_q.ip == cmd_i.key);
    end
  end

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (cmd_i.op)
      arpc_pkg::OP_INSERT: begin
        valid_d = prev_i.valid;
        data_d  = prev_i;
      end
      arpc_pkg::OP_REMOVE: begin
        if (seen_o) begin
          valid_d = next_i.valid;
          data_d  = next_i;
        end
      end
      arpc_pkg::OP_UPD_MAC: begin
        if (first_o) begin
          data_d.mac = cmd_i.mac;
        end
      end
      arpc_pkg::OP_RESOLVE: begin
        if (first_o) begin
          data_d.mac      = cmd_i.mac;
          data_d.intf     = cmd_i.intf;
          data_d.resolved = 1'b1;
        end
      end
      arpc_pkg::OP_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

@@ rtl/arp_cache_table.sv @@
// ARP cache table top level: request control and a row of entry cells.
//
// Input channel (in_valid_i/in_ready_o) carries one request word: a mode,
// an IPv4 key, a MAC, an interface index and a resolved flag. Output channel
// (out_valid_o/out_ready_i) returns exactly one result word per request:
// status, found flag and the fields of the first matching entry as they
// stood before the request.
// Each request runs in steps: the accepted word is registered, every
// cell compares its IP against the key and registers a match bit, and in the
// execute state the first match is picked by a chain through the cells, the
// update is applied to the row and the result is loaded into the output
// register once that register is free or being emptied. A new word is not
// accepted until the previous request has loaded its result.
// Entries are held newest first; an insert shifts the whole row one cell
// back, a delete shifts the cells behind the match one cell forward.
// Reset invalidates every entry at once. While the receiver stalls, the
// result waits in the output register; the next word is still accepted and
// compared, and its update waits until the held result is taken.
module arp_cache_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [arpc_pkg::ModeW-1:0]     mode_i,
  input  logic [arpc_pkg::IpW-1:0]       ip_key_i,
  input  logic [arpc_pkg::MacW-1:0]      mac_in_i,
  input  logic [arpc_pkg::IntfW-1:0]     intf_in_i,
  input  logic                           resolved_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [arpc_pkg::StatusW-1:0]   status_o,
  output logic                           found_o,
  output logic [arpc_pkg::MacW-1:0]      mac_out_o,
  output logic [arpc_pkg::IntfW-1:0]     intf_out_o,
  output logic                           resolved_out_o
);

  localparam int Depth = arpc_pkg::TableDepth;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_e;

  state_e                         state_q;
  logic [arpc_pkg::ModeW-1:0]     mode_q;
  logic [arpc_pkg::IpW-1:0]       ip_q;
  logic [arpc_pkg::MacW-1:0]      mac_q;
  logic [arpc_pkg::IntfW-1:0]     intf_q;
  logic                           res_q;
  logic [arpc_pkg::IntfW-1:0]     intf_sat;

  logic                           out_valid_q;
  logic [arpc_pkg::StatusW-1:0]   status_q;
  logic                           found_q;
  logic [arpc_pkg::MacW-1:0]      mac_out_q;
  logic [arpc_pkg::IntfW-1:0]     intf_out_q;
  logic                           res_out_q;

  arpc_pkg::cell_cmd_t            cmd;
  arpc_pkg::entry_t               entries [Depth];
  arpc_pkg::entry_t               prev_in [Depth];
  arpc_pkg::entry_t               next_in [Depth];
  logic [Depth:0]                 seen;
  logic [Depth-1:0]               first_vec;
  logic [Depth-1:0]               valid_vec;

  arpc_pkg::entry_t               hit_entry;
  logic                           hit_any;
  logic                           fire;
  logic                           search_en;
  arpc_pkg::cell_op_e             op_sel;
  arpc_pkg::status_e              status_sel;
  logic                           found_sel;
  logic                           full;

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign mac_out_o      = mac_out_q;
  assign intf_out_o     = intf_out_q;
  assign resolved_out_o = res_out_q;

  always_comb begin
    intf_sat = intf_in_i;
    if (32'(intf_in_i) >= arpc_pkg::IntfCount) begin
      intf_sat = arpc_pkg::IntfW'(arpc_pkg::IntfCount - 1);
    end
  end

  // Modes above delete never search the table.
  assign search_en = (mode_q <= arpc_pkg::ModeW'(arpc_pkg::MODE_DELETE));
  assign fire      = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < Depth; i++) begin
      hit_entry = hit_entry | (first_vec[i] ? entries[i] : '0);
    end
    hit_any = |first_vec;
    full    = valid_vec[Depth-1];
  end

  always_comb begin
    op_sel     = arpc_pkg::OP_NONE;
    status_sel = arpc_pkg::ST_OK;
    found_sel  = hit_any;
    case (mode_q)
      arpc_pkg::MODE_LOOKUP: begin
        status_sel = hit_any ? arpc_pkg::ST_OK : arpc_pkg::ST_NOT_FOUND;
      end
      arpc_pkg::MODE_ADD: begin
        if (hit_any && (hit_entry.intf == intf_q)) begin
          op_sel = arpc_pkg::OP_UPD_MAC;
        end else if (full) begin
          status_sel = arpc_pkg::ST_FULL;
        end else begin
          op_sel = arpc_pkg::OP_INSERT;
        end
      end
      arpc_pkg::MODE_ADD_UNR: begin
        if (hit_any) begin
          status_sel = arpc_pkg::ST_PRESENT;
        end else if (full) begin
          status_sel = arpc_pkg::ST_FULL;
        end else begin
          op_sel = arpc_pkg::OP_INSERT;
        end
      end
      arpc_pkg::MODE_RESOLVE: begin
        if (!hit_any) begin
          status_sel = arpc_pkg::ST_NOT_FOUND;
        end else if (hit_entry.resolved) begin
          status_sel = arpc_pkg::ST_RESOLVED;
        end else begin
          op_sel = arpc_pkg::OP_RESOLVE;
        end
      end
      arpc_pkg::MODE_DELETE: begin
        if (!hit_any) begin
          status_sel = arpc_pkg::ST_NOT_FOUND;
        end else begin
          op_sel = arpc_pkg::OP_REMOVE;
        end
      end
      arpc_pkg::MODE_CLEAR: begin
        op_sel    = arpc_pkg::OP_CLEAR;
        found_sel = 1'b0;
      end
      default: begin
        found_sel = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.op       = fire ? op_sel : arpc_pkg::OP_NONE;
    cmd.cmp_en   = (state_q == S_CMP);
    cmd.key      = ip_q;
    cmd.mac      = mac_q;
    cmd.intf     = intf_q;
    cmd.resolved = res_q;
  end

  // The newest entry enters at the front; an unresolved add stores zeros.
  always_comb begin
    prev_in[0]       = '0;
    prev_in[0].valid = 1'b1;
    prev_in[0].ip    = ip_q;
    if (mode_q == arpc_pkg::ModeW'(arpc_pkg::MODE_ADD)) begin
      prev_in[0].mac      = mac_q;
      prev_in[0].intf     = intf_q;
      prev_in[0].resolved = res_q;
    end
    for (int i = 1; i < Depth; i++) begin
      prev_in[i] = entries[i-1];
    end
    for (int i = 0; i < Depth - 1; i++) begin
      next_in[i] = entries[i+1];
    end
    next_in[Depth-1] = '0;
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic cell_first;
    arpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .prev_i  (prev_in[g]),
      .next_i  (next_in[g]),
      .seen_i  (seen[g]),
      .seen_o  (seen[g+1]),
      .first_o (cell_first),
      .entry_o (entries[g])
    );
    assign first_vec[g] = cell_first & search_en;
    assign valid_vec[g] = entries[g].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= '0;
      ip_q        <= '0;
      mac_q       <= '0;
      intf_q      <= '0;
      res_q       <= 1'b0;
      status_q    <= '0;
      found_q     <= 1'b0;
      mac_out_q   <= '0;
      intf_out_q  <= '0;
      res_out_q   <= 1'b0;
    end else begin
      // A new result loaded at this edge takes the place of the one leaving.
      if (out_valid_q && out_ready_i && !fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            ip_q    <= ip_key_i;
            mac_q   <= mac_in_i;
            intf_q  <= intf_sat;
            res_q   <= resolved_in_i;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (fire) begin
            out_valid_q <= 1'b1;
            status_q    <= status_sel;
            found_q     <= found_sel;
            mac_out_q   <= found_sel ? hit_entry.mac : '0;
            intf_out_q  <= found_sel ? hit_entry.intf : '0;
            res_out_q   <= found_sel ? hit_entry.resolved : 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_to_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_CMP)
    else $error("accepted word did not start a compare");

  a_first_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_vec))
    else $error("more than one first match");

  a_valid_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + Depth'(1)) & valid_vec) == '0)
    else $error("valid entries are not packed at the front");

  a_result_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EXEC)
    else $error("result appeared outside the execute cycle");

endmodule

@@ tb/arp_cache_checker.sv @@
// Checker for the ARP cache table: predicts every result word and compares it with the block.
module arp_cache_checker
  import arpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_ready_i,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [IpW-1:0]     ip_key_i,
  input  logic [MacW-1:0]    mac_in_i,
  input  logic [IntfW-1:0]   intf_in_i,
  input  logic               resolved_in_i,
  input  logic               rsp_valid_i,
  input  logic               rsp_ready_i,
  input  logic [StatusW-1:0] status_i,
  input  logic               found_i,
  input  logic [MacW-1:0]    mac_out_i,
  input  logic [IntfW-1:0]   intf_out_i,
  input  logic               resolved_out_i,
  output int                 mismatches_o,
  output int                 outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ShownMax = 10;

  typedef struct packed {
    status_e          status;
    logic             found;
    logic [MacW-1:0]  mac;
    logic [IntfW-1:0] intf;
    logic             resolved;
  } reply_t;

  entry_t cache [TableDepth];
  reply_t replies_q [$];
  int     mismatches = 0;

  function automatic void push_entry(int used, entry_t ent);
    int k;
    for (k = used; k > 0; k--) cache[k] = cache[k-1];
    cache[0] = ent;
  endfunction

  // Applies one request to the predicted cache and returns the word it should produce.
  function automatic reply_t cache_access(logic [ModeW-1:0] mode, logic [IpW-1:0] ip,
                                          logic [MacW-1:0] mac, logic [IntfW-1:0] intf_raw,
                                          logic res);
    reply_t           rep;
    int               hit;
    int               used;
    int               k;
    logic [IntfW-1:0] intf;
    rep  = '0;
    hit  = -1;
    used = 0;
    intf = (int'(intf_raw) >= IntfCount) ? IntfW'(IntfCount - 1) : intf_raw;
    for (k = 0; k < TableDepth; k++) begin
      if (cache[k].valid) used++;
      if (mode <= MODE_DELETE && hit < 0 && cache[k].valid && cache[k].ip == ip) hit = k;
    end
    if (hit >= 0) begin
      rep.found    = 1'b1;
      rep.mac      = cache[hit].mac;
      rep.intf     = cache[hit].intf;
      rep.resolved = cache[hit].resolved;
    end
    rep.status = ST_OK;
    case (mode)
      MODE_LOOKUP: begin
        if (hit < 0) rep.status = ST_NOT_FOUND;
      end
      MODE_ADD: begin
        if (hit >= 0 && cache[hit].intf == intf) cache[hit].mac = mac;
        else if (used >= TableDepth) rep.status = ST_FULL;
        else push_entry(used, entry_t'{valid: 1'b1, ip: ip, mac: mac, intf: intf,
                                       resolved: res});
      end
      MODE_ADD_UNR: begin
        if (hit >= 0) rep.status = ST_PRESENT;
        else if (used >= TableDepth) rep.status = ST_FULL;
        else push_entry(used, entry_t'{valid: 1'b1, ip: ip, mac: '0, intf: '0,
                                       resolved: 1'b0});
      end
      MODE_RESOLVE: begin
        if (hit < 0) begin
          rep.status = ST_NOT_FOUND;
        end else if (cache[hit].resolved) begin
          rep.status = ST_RESOLVED;
        end else begin
          cache[hit].mac      = mac;
          cache[hit].intf     = intf;
          cache[hit].resolved = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (hit < 0) begin
          rep.status = ST_NOT_FOUND;
        end else begin
          for (k = hit; k < TableDepth - 1; k++) cache[k] = cache[k+1];
          cache[TableDepth-1].valid = 1'b0;
        end
      end
      MODE_CLEAR: begin
        for (k = 0; k < TableDepth; k++) cache[k].valid = 1'b0;
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= ShownMax) $display("%0t ns: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    reply_t want;
    reply_t got;
    int     k;
    if (!rst_ni) begin
      for (k = 0; k < TableDepth; k++) cache[k] = '0;
      replies_q.delete();
    end else begin
      // The result word leaving at this edge belongs to an earlier request.
      if (rsp_valid_i && rsp_ready_i) begin
        got.status   = status_e'(status_i);
        got.found    = found_i;
        got.mac      = mac_out_i;
        got.intf     = intf_out_i;
        got.resolved = resolved_out_i;
        if (replies_q.size() == 0) begin
          note_mismatch($sformatf("result word with none expected: status %0d found %0b",
                                  status_i, found_i));
        end else begin
          want = replies_q.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.mac !== want.mac || got.intf !== want.intf ||
              got.resolved !== want.resolved) begin
            note_mismatch($sformatf(
              "got status %0d found %0b mac %h intf %0d res %0b, expected %0d %0b %h %0d %0b",
              got.status, got.found, got.mac, got.intf, got.resolved,
              want.status, want.found, want.mac, want.intf, want.resolved));
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        replies_q.push_back(cache_access(mode_i, ip_key_i, mac_in_i, intf_in_i,
                                         resolved_in_i));
      end
    end
    mismatches_o  = mismatches;
    outstanding_o = replies_q.size();
  end

endmodule

@@ tb/arp_cache_table_tb.sv @@
// Top of the ARP cache table testbench: clock, reset, request and result traffic, verdict.
module arp_cache_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arpc_pkg::*;

  localparam int ClkHalf       = 6;
  localparam int IdleMax       = 17;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 20;
  localparam int RandItems     = 1250;
  localparam int QuietItems    = 150;
  localparam int SegmentLen    = 50;
  localparam int PoolSize      = 20;

  // Mode codes the block does not define; they must leave the cache alone.
  localparam logic [ModeW-1:0] ModeSpareLo = 3'd6;
  localparam logic [ModeW-1:0] ModeSpareHi = 3'd7;

  localparam logic [IpW-1:0]   IpLow   = '0;
  localparam logic [IpW-1:0]   IpHigh  = '1;
  localparam logic [MacW-1:0]  MacOnes = '1;
  localparam logic [IntfW-1:0] IntfTop = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ModeW-1:0]   mode_i;
  logic [IpW-1:0]     ip_key_i;
  logic [MacW-1:0]    mac_in_i;
  logic [IntfW-1:0]   intf_in_i;
  logic               resolved_in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [StatusW-1:0] status_o;
  logic               found_o;
  logic [MacW-1:0]    mac_out_o;
  logic [IntfW-1:0]   intf_out_o;
  logic               resolved_out_o;

  int             mismatches;
  int             outstanding;
  int             stall_cycles = 0;
  bit             idle_en = 1'b1;
  logic [IpW-1:0] ip_pool [PoolSize];

  always #(ClkHalf) clk_i = ~clk_i;

  arp_cache_table i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .ip_key_i       (ip_key_i),
    .mac_in_i       (mac_in_i),
    .intf_in_i      (intf_in_i),
    .resolved_in_i  (resolved_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_o        (found_o),
    .mac_out_o      (mac_out_o),
    .intf_out_o     (intf_out_o),
    .resolved_out_o (resolved_out_o)
  );

  arp_cache_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_ready_i    (in_ready_o),
    .mode_i         (mode_i),
    .ip_key_i       (ip_key_i),
    .mac_in_i       (mac_in_i),
    .intf_in_i      (intf_in_i),
    .resolved_in_i  (resolved_in_i),
    .rsp_valid_i    (out_valid_o),
    .rsp_ready_i    (out_ready_i),
    .status_i       (status_o),
    .found_i        (found_o),
    .mac_out_i      (mac_out_o),
    .intf_out_i     (intf_out_o),
    .resolved_out_i (resolved_out_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  // Offers one request word, possibly after an idle burst, and returns at the accepting edge.
  task automatic send_word(logic [ModeW-1:0] mode, logic [IpW-1:0] ip,
                           logic [MacW-1:0] mac, logic [IntfW-1:0] intf, logic res);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, IdleMax)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    ip_key_i      <= ip;
    mac_in_i      <= mac;
    intf_in_i     <= intf;
    resolved_in_i <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // A random request; keys mostly come from a small pool so that entries get hit,
  // and a filling segment leans on inserts so that the cache runs full.
  task automatic send_random(bit filling);
    int               r;
    logic [ModeW-1:0] mode;
    logic [IpW-1:0]   ip;
    logic [MacW-1:0]  mac;
    logic [IntfW-1:0] intf;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 35)      mode = MODE_ADD;
      else if (r < 65) mode = MODE_ADD_UNR;
      else if (r < 80) mode = MODE_LOOKUP;
      else if (r < 92) mode = MODE_RESOLVE;
      else             mode = MODE_DELETE;
    end else begin
      if (r < 25)      mode = MODE_LOOKUP;
      else if (r < 45) mode = MODE_ADD;
      else if (r < 60) mode = MODE_ADD_UNR;
      else if (r < 75) mode = MODE_RESOLVE;
      else if (r < 95) mode = MODE_DELETE;
      else if (r < 98) mode = MODE_CLEAR;
      else             mode = $urandom_range(0, 1) ? ModeSpareHi : ModeSpareLo;
    end
    if ($urandom_range(0, 24) == 0) ip_pool[$urandom_range(2, PoolSize - 1)] = $urandom;
    ip  = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, PoolSize - 1)] : $urandom;
    r   = $urandom_range(0, 19);
    mac = (r == 0) ? '0 : (r == 1) ? MacOnes : MacW'({$urandom, $urandom});
    intf = ($urandom_range(0, 3) != 0) ? IntfW'($urandom_range(0, 2))
                                       : IntfW'($urandom_range(0, IntfCount - 1));
    send_word(mode, ip, mac, intf, 1'($urandom_range(0, 1)));
  endtask

  initial begin : receiver
    out_ready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, IdleMax)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("arp_cache_table verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    bit filling;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_LOOKUP;
    ip_key_i      = '0;
    mac_in_i      = '0;
    intf_in_i     = '0;
    resolved_in_i = 1'b0;
    ip_pool[0] = IpLow;
    ip_pool[1] = IpHigh;
    for (n = 2; n < PoolSize; n++) ip_pool[n] = $urandom;
    filling = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty cache: every keyed operation misses.
    send_word(MODE_LOOKUP,  IpLow,  '0, '0, 1'b0);
    send_word(MODE_DELETE,  IpHigh, '0, '0, 1'b0);
    send_word(MODE_RESOLVE, IpLow,  MacOnes, IntfTop, 1'b1);
    // Insert, then a same-interface add only replaces the MAC.
    send_word(MODE_ADD,    IpLow, MacOnes, IntfTop, 1'b1);
    send_word(MODE_ADD,    IpLow, '0, IntfTop, 1'b0);
    send_word(MODE_LOOKUP, IpLow, '0, '0, 1'b0);
    // A different interface inserts a second entry with the same IP in front.
    send_word(MODE_ADD,     IpLow, 48'h0123_4567_89ab, '0, 1'b0);
    send_word(MODE_LOOKUP,  IpLow, '0, '0, 1'b0);
    send_word(MODE_ADD_UNR, IpLow, MacOnes, IntfTop, 1'b1);
    // Resolving an unresolved entry works once; the second attempt finds it resolved.
    send_word(MODE_RESOLVE, IpLow, 48'hfedc_ba98_7654, 4'd3, 1'b0);
    send_word(MODE_RESOLVE, IpLow, MacOnes, IntfTop, 1'b1);
    send_word(MODE_ADD_UNR, IpHigh, MacOnes, IntfTop, 1'b1);
    send_word(MODE_RESOLVE, IpHigh, MacOnes, IntfTop, 1'b0);
    // Deleting the newest match uncovers the older one.
    send_word(MODE_DELETE, IpLow, '0, '0, 1'b0);
    send_word(MODE_LOOKUP, IpLow, '0, '0, 1'b0);
    send_word(ModeSpareLo, IpLow,  MacOnes, IntfTop, 1'b1);
    send_word(ModeSpareHi, IpHigh, MacOnes, IntfTop, 1'b1);
    send_word(MODE_CLEAR,  IpHigh, MacOnes, IntfTop, 1'b1);
    send_word(MODE_LOOKUP, IpHigh, '0, '0, 1'b0);
    send_word(MODE_LOOKUP, IpLow,  '0, '0, 1'b0);

    for (n = 0; n < RandItems; n++) begin
      if (n % SegmentLen == 0) begin
        filling = ($urandom_range(0, 2) == 0);
        idle_en = ($urandom_range(0, 3) != 0);
      end
      if (n >= RandItems - QuietItems) idle_en = 1'b0;
      send_random(filling);
    end
    in_valid_i <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("arp_cache_table verification clean");
    else
      $display("arp_cache_table verification failed");
    $finish;
  end

endmodule
